>>> hw/rtl/i2cms_pkg.sv
`timescale 1ns / 1ps
// types and constants shared by the i2c master bit sequencer
// no dependencies

package i2cms_pkg;

    // command codes on the request channel
    localparam logic [2:0] CMD_TICK     = 3'd0;
    localparam logic [2:0] CMD_ALT_TICK = 3'd7;

    typedef enum logic [2:0] {
        OP_IDLE  = 3'd0,
        OP_START = 3'd1,
        OP_STOP  = 3'd2,
        OP_SEND  = 3'd3,
        OP_RECV  = 3'd4,
        OP_SACK  = 3'd5,
        OP_RACK  = 3'd6
    } t_op;

    localparam logic [2:0] LAST_BIT = 3'd7;

    typedef struct packed {
        t_op        op;
        logic [1:0] step;
        logic [2:0] bitc;
        logic [7:0] shift_out;
        logic [7:0] shift_in;
        logic       scl;
        logic       sda;
    } t_state;

    typedef struct packed {
        logic       scl;
        logic       sda_release;
        logic       busy;
        logic       done;
        logic [7:0] rx_byte;
        logic       rx_ack;
        logic       rejected;
    } t_result;

endpackage

>>> hw/rtl/i2cms_step.sv
`timescale 1ns / 1ps
// one pin step of the sequencer: next state and result for one request
// depends on i2cms_pkg

module i2cms_step (
    input  i2cms_pkg::t_state  i_state,
    input  logic [2:0]         i_command,
    input  logic [7:0]         i_tx_byte,
    input  logic               i_sda_in,
    output i2cms_pkg::t_state  o_state,
    output i2cms_pkg::t_result o_result
);

    logic is_cmd;
    logic last;
    logic rej;
    logic [7:0] rxb;
    logic rxa;
    i2cms_pkg::t_state n_st;

    assign is_cmd = (i_command != i2cms_pkg::CMD_TICK) &&
                    (i_command != i2cms_pkg::CMD_ALT_TICK);

    always_comb begin
        n_st = i_state;
        last = 1'b0;
        rej  = 1'b0;
        rxb  = 8'd0;
        rxa  = 1'b0;
        if (is_cmd) begin
            if (i_state.op != i2cms_pkg::OP_IDLE) begin
                rej = 1'b1;
            end else begin
                n_st.op        = i2cms_pkg::t_op'(i_command);
                n_st.step      = 2'd0;
                n_st.bitc      = 3'd0;
                n_st.shift_out = i_tx_byte;
                n_st.shift_in  = 8'd0;
            end
        end else if (i_state.op != i2cms_pkg::OP_IDLE) begin
            n_st.step = i_state.step + 2'd1;
            unique case (i_state.op)
                i2cms_pkg::OP_START: begin
                    unique case (i_state.step)
                        2'd0: n_st.sda = 1'b1;
                        2'd1: n_st.scl = 1'b1;
                        2'd2: n_st.sda = 1'b0;
                        default: begin
                            n_st.scl = 1'b0;
                            last     = 1'b1;
                        end
                    endcase
                end
                i2cms_pkg::OP_STOP: begin
                    unique case (i_state.step)
                        2'd0: n_st.sda = 1'b0;
                        2'd1: n_st.scl = 1'b1;
                        default: begin
                            n_st.sda = 1'b1;
                            last     = 1'b1;
                        end
                    endcase
                end
                i2cms_pkg::OP_SEND: begin
                    unique case (i_state.step)
                        2'd0: n_st.sda = i_state.shift_out[7];
                        2'd1: n_st.scl = 1'b1;
                        default: begin
                            n_st.scl       = 1'b0;
                            n_st.shift_out = {i_state.shift_out[6:0], 1'b0};
                            if (i_state.bitc == i2cms_pkg::LAST_BIT) begin
                                last = 1'b1;
                            end else begin
                                n_st.step = 2'd0;
                                n_st.bitc = i_state.bitc + 3'd1;
                            end
                        end
                    endcase
                end
                i2cms_pkg::OP_RECV: begin
                    unique case (i_state.step)
                        2'd0: n_st.sda = 1'b1;
                        2'd1: n_st.scl = 1'b1;
                        default: begin
                            n_st.scl      = 1'b0;
                            n_st.shift_in = {i_state.shift_in[6:0], i_sda_in};
                            if (i_state.bitc == i2cms_pkg::LAST_BIT) begin
                                last = 1'b1;
                                rxb  = {i_state.shift_in[6:0], i_sda_in};
                            end else begin
                                n_st.step = 2'd1;
                                n_st.bitc = i_state.bitc + 3'd1;
                            end
                        end
                    endcase
                end
                i2cms_pkg::OP_SACK: begin
                    unique case (i_state.step)
                        2'd0: n_st.sda = |i_state.shift_out;
                        2'd1: n_st.scl = 1'b1;
                        default: begin
                            n_st.scl = 1'b0;
                            last     = 1'b1;
                        end
                    endcase
                end
                i2cms_pkg::OP_RACK: begin
                    unique case (i_state.step)
                        2'd0: n_st.sda = 1'b1;
                        2'd1: n_st.scl = 1'b1;
                        default: begin
                            n_st.scl = 1'b0;
                            rxa      = i_sda_in;
                            last     = 1'b1;
                        end
                    endcase
                end
                default: last = 1'b1;
            endcase
            if (last) begin
                n_st.op   = i2cms_pkg::OP_IDLE;
                n_st.step = 2'd0;
                n_st.bitc = 3'd0;
            end
        end
    end

    assign o_state              = n_st;
    assign o_result.scl         = n_st.scl;
    assign o_result.sda_release = n_st.sda;
    assign o_result.busy        = (n_st.op != i2cms_pkg::OP_IDLE);
    assign o_result.done        = last;
    assign o_result.rx_byte     = rxb;
    assign o_result.rx_ack      = rxa;
    assign o_result.rejected    = rej;

endmodule

>>> hw/rtl/i2c_master_bit_sequencer_unit.sv
`timescale 1ns / 1ps
// top level of the i2c master bit sequencer: request register, sequencer state, result register
// depends on i2cms_pkg and i2cms_step

// The sequencer drives open-drain scl and sda one pin write per tick request. A
// request with a command code (start, stop, send byte, receive byte, send ack,
// receive ack) loads the operation and moves no pin; each following tick request
// then performs one write of that operation's sequence and returns the pin levels.
// Receive steps sample i_sda_in on the tick that drives scl low after it was
// released. A command that arrives while an operation is running is flagged with
// o_rejected and otherwise ignored; command code seven acts as a tick. Every
// request gives exactly one result. Throughput is one request per clock while
// i_out_ready takes each result, set by the update of the sequencer state register;
// the request passes from the request register to the result register, which
// holds the result until it is taken. While a result waits, one more request is
// taken into the empty request register and held there.

module i2c_master_bit_sequencer_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [2:0] i_command,
    input  logic [7:0] i_tx_byte,
    input  logic       i_sda_in,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_scl,
    output logic       o_sda_release,
    output logic       o_busy_res,
    output logic       o_done_res,
    output logic [7:0] o_rx_byte,
    output logic       o_rx_ack,
    output logic       o_rejected
);

    // request register
    logic       r_in_valid;
    logic [2:0] r_command;
    logic [7:0] r_tx_byte;
    logic       r_sda_in;

    // sequencer state and result register
    i2cms_pkg::t_state  r_state;
    i2cms_pkg::t_state  n_state;
    i2cms_pkg::t_result r_result;
    i2cms_pkg::t_result n_result;
    logic               r_out_valid;

    logic advance;
    logic in_fire;

    // the held request moves on when the result register is free or being drained
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;
    assign in_fire    = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_fire) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    // payload needs no reset
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_command <= i_command;
            r_tx_byte <= i_tx_byte;
            r_sda_in  <= i_sda_in;
        end
    end

    i2cms_step u_step (
        .i_state   (r_state),
        .i_command (r_command),
        .i_tx_byte (r_tx_byte),
        .i_sda_in  (r_sda_in),
        .o_state   (n_state),
        .o_result  (n_result)
    );

    // pins released and idle out of reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.op        <= i2cms_pkg::OP_IDLE;
            r_state.step      <= 2'd0;
            r_state.bitc      <= 3'd0;
            r_state.shift_out <= 8'd0;
            r_state.shift_in  <= 8'd0;
            r_state.scl       <= 1'b1;
            r_state.sda       <= 1'b1;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_scl         = r_result.scl;
    assign o_sda_release = r_result.sda_release;
    assign o_busy_res    = r_result.busy;
    assign o_done_res    = r_result.done;
    assign o_rx_byte     = r_result.rx_byte;
    assign o_rx_ack      = r_result.rx_ack;
    assign o_rejected    = r_result.rejected;

endmodule

>>> hw/rtl/i2cms_checker.sv
`timescale 1ns / 1ps
// port-level checks for the i2c master bit sequencer, bound to the top level
// depends on i2c_master_bit_sequencer_unit

module i2cms_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic       o_scl,
    input logic       o_sda_release,
    input logic       o_busy_res,
    input logic       o_done_res,
    input logic [7:0] o_rx_byte,
    input logic       o_rx_ack,
    input logic       o_rejected
);

    // a finished operation leaves the sequencer idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_done_res |-> !o_busy_res)
        else $error("done reported while still busy");

    // received data only shows with done
    a_rx_with_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && ((o_rx_byte != 8'd0) || o_rx_ack) |-> o_done_res)
        else $error("receive data without done");

    // a reject only happens while busy and finishes nothing
    a_reject_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_rejected |-> o_busy_res && !o_done_res)
        else $error("reject while idle or with done");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_rx_byte)
            && $stable(o_scl) && $stable(o_sda_release) && $stable(o_done_res))
        else $error("stalled result changed");

endmodule

bind i2c_master_bit_sequencer_unit i2cms_checker u_i2cms_checker (.*);
